>>> sv/b2b_pkg.sv
// Package for the BLAKE2b-256 hasher: IV, message schedule and shared types.
// Depends on nothing; used by b2b_core and blake2b_256_hasher.
package b2b_pkg;

  typedef logic [63:0] word_t;

  localparam word_t IV0 = 64'h6a09e667f3bcc908;
  localparam word_t IV1 = 64'hbb67ae8584caa73b;
  localparam word_t IV2 = 64'h3c6ef372fe94f82b;
  localparam word_t IV3 = 64'ha54ff53a5f1d36f1;
  localparam word_t IV4 = 64'h510e527fade682d1;
  localparam word_t IV5 = 64'h9b05688c2b3e6c1f;
  localparam word_t IV6 = 64'h1f83d9abfb41bd6b;
  localparam word_t IV7 = 64'h5be0cd19137e2179;
  localparam word_t PARAM_WORD = 64'h0000000001010020;
  localparam logic [7:0] BLOCK_BYTES = 8'd128;

  function automatic word_t iv_word(input logic [2:0] i);
    word_t v;
    case (i)
      3'd0: v = IV0;
      3'd1: v = IV1;
      3'd2: v = IV2;
      3'd3: v = IV3;
      3'd4: v = IV4;
      3'd5: v = IV5;
      3'd6: v = IV6;
      default: v = IV7;
    endcase
    return v;
  endfunction

  // Message word index for round r (0..11) and slot s (0..15).
  function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] s);
    logic [63:0] row;
    case (r)
      4'd0, 4'd10: row = 64'hfedcba9876543210;
      4'd1, 4'd11: row = 64'h357b20c16df984ae;
      4'd2:        row = 64'h491763eadf250c8b;
      4'd3:        row = 64'h8f04a562ebcd1397;
      4'd4:        row = 64'hd386cb1efa427509;
      4'd5:        row = 64'h91ef57d438b0a6c2;
      4'd6:        row = 64'hb8293670a4def15c;
      4'd7:        row = 64'ha2684f05931ce7bd;
      4'd8:        row = 64'h5a417d2c803b9ef6;
      default:     row = 64'h0dc3e9bf5167482a;
    endcase
    return row[{s, 2'b00} +: 4];
  endfunction

  typedef struct packed {
    logic start;
    logic final_blk;
  } core_cmd_t;

endpackage

>>> sv/b2b_core.sv
// BLAKE2b compression unit: one shared G half-step per cycle, 12 rounds.
// Depends on b2b_pkg. Takes the message block as a flat vector.
module b2b_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  b2b_pkg::core_cmd_t      cmd,
  input  logic [1023:0]           msg,
  input  logic [127:0]            counter,
  input  logic [511:0]            h_in,
  output logic [511:0]            h_out,
  output logic                    done
);
  import b2b_pkg::*;

  word_t v_r [16];
  word_t v_nxt [16];
  logic [3:0] round_r, round_nxt;
  logic [2:0] g_r, g_nxt;
  logic half_r, half_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  logic [3:0] ia, ib, ic, id;
  word_t a, b, c, d, m, a1, d1, c1, b1, dx, bx;
  logic [3:0] midx;

  always_comb begin
    case (g_r)
      3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
      3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
      3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
      3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
      3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
      3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
      3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
      default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
    endcase
    midx = sigma(round_r, {g_r, half_r});
    m = msg[{midx, 6'd0} +: 64];
    a = v_r[ia];
    b = v_r[ib];
    c = v_r[ic];
    d = v_r[id];
    a1 = a + b + m;
    dx = d ^ a1;
    if (!half_r) begin
      d1 = {dx[31:0], dx[63:32]};
      c1 = c + d1;
      bx = b ^ c1;
      b1 = {bx[23:0], bx[63:24]};
    end else begin
      d1 = {dx[15:0], dx[63:16]};
      c1 = c + d1;
      bx = b ^ c1;
      b1 = {bx[62:0], bx[63]};
    end
  end

  always_comb begin
    v_nxt = v_r;
    round_nxt = round_r;
    g_nxt = g_r;
    half_nxt = half_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) begin
        v_nxt[i] = h_in[i*64 +: 64];
        v_nxt[i+8] = iv_word(3'(i));
      end
      v_nxt[12] = IV4 ^ counter[63:0];
      v_nxt[13] = IV5 ^ counter[127:64];
      v_nxt[14] = cmd.final_blk ? ~IV6 : IV6;
      round_nxt = '0;
      g_nxt = '0;
      half_nxt = 1'b0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt[ia] = a1;
      v_nxt[ib] = b1;
      v_nxt[ic] = c1;
      v_nxt[id] = d1;
      half_nxt = ~half_r;
      if (half_r) begin
        g_nxt = g_r + 3'd1;
        if (g_r == 3'd7) begin
          if (round_r == 4'd11) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            round_nxt = round_r + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    v_r <= v_nxt;
    round_r <= round_nxt;
    g_r <= g_nxt;
    half_r <= half_nxt;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      h_out[i*64 +: 64] = h_in[i*64 +: 64] ^ v_r[i] ^ v_r[i+8];
    end
  end

  assign done = done_r;

endmodule

>>> sv/blake2b_256_hasher.sv
// A word that needs no compression frees the input after the PRE state; one that finds
// a full held block first runs a compression of 192 half G steps (12 rounds x 16) and
// frees the input once it is done. A final word adds padding and one compression; the
// first of its 4 digest transactions is offered once that compression is done.
// rst_n (synchronous, active low) restores the IV and clears counters.
module blake2b_256_hasher (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  b2b_pkg::word_t        in_msg_word,
  input  logic [3:0]            in_byte_count,
  input  logic                  in_end_of_message,
  output logic                  out_valid,
  input  logic                  out_ready,
  output b2b_pkg::word_t        out_digest_word,
  output logic [1:0]            out_word_index,
  output logic                  out_digest_last
);
  import b2b_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRE  = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  logic [2:0] state_r, state_nxt;
  logic [511:0] h_r, h_nxt, h_core;
  logic [1023:0] blk_r, blk_nxt;
  logic [127:0] cnt_r, cnt_nxt;
  logic [7:0] fill_r, fill_nxt;
  word_t word_r, word_nxt;
  logic [3:0] bc_r, bc_nxt;
  logic last_r, last_nxt;
  logic [1:0] oidx_r, oidx_nxt;
  core_cmd_t cmd;
  logic core_done;
  logic [3:0] cnt_eff;
  word_t masked;
  logic [4:0] used;

  b2b_core u_core (
    .clk, .rst_n, .cmd, .msg(blk_r), .counter(cnt_nxt), .h_in(h_r),
    .h_out(h_core), .done(core_done)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_digest_word = h_r[{oidx_r, 6'd0} +: 64];
  assign out_word_index = oidx_r;
  assign out_digest_last = (oidx_r == 2'd3);

  always_comb begin
    cnt_eff = (bc_r > 4'd8 || !last_r) ? 4'd8 : bc_r;
    masked = word_r;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) >= cnt_eff) masked[k*8 +: 8] = 8'h00;
    end
    used = 5'((fill_r + 8'd7) >> 3);
  end

  always_comb begin
    state_nxt = state_r;
    h_nxt = h_r;
    blk_nxt = blk_r;
    cnt_nxt = cnt_r;
    fill_nxt = fill_r;
    word_nxt = word_r;
    bc_nxt = bc_r;
    last_nxt = last_r;
    oidx_nxt = oidx_r;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          word_nxt = in_msg_word;
          bc_nxt = in_byte_count;
          last_nxt = in_end_of_message;
          state_nxt = ST_PRE;
        end
      end
      ST_PRE: begin
        if (cnt_eff != 4'd0 && fill_r >= BLOCK_BYTES && !core_done) begin
          cnt_nxt = cnt_r + 128'(BLOCK_BYTES);
          cmd.start = 1'b1;
          fill_nxt = BLOCK_BYTES + 8'd1;
          state_nxt = ST_FIN;
        end else begin
          if (cnt_eff != 4'd0) begin
            blk_nxt[{fill_r[6:3], 6'd0} +: 64] = masked;
            fill_nxt = fill_r + 8'(cnt_eff);
          end
          if (last_r) begin
            state_nxt = ST_FIN;
            last_nxt = 1'b0;
            bc_nxt = 4'd15;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (fill_r == BLOCK_BYTES + 8'd1) begin
          if (core_done) begin
            h_nxt = h_core;
            fill_nxt = 8'd0;
            state_nxt = ST_PRE;
          end
        end else if (bc_r == 4'd15) begin
          cnt_nxt = cnt_r + 128'(fill_r);
          for (int i = 0; i < 16; i++) begin
            if (5'(i) >= used) blk_nxt[i*64 +: 64] = 64'd0;
          end
          bc_nxt = 4'd0;
        end else if (bc_r == 4'd0) begin
          cmd.start = 1'b1;
          cmd.final_blk = 1'b1;
          bc_nxt = 4'd1;
        end else if (core_done) begin
          h_nxt = h_core;
          oidx_nxt = 2'd0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            state_nxt = ST_IDLE;
            h_nxt = {IV7, IV6, IV5, IV4, IV3, IV2, IV1, IV0 ^ PARAM_WORD};
            cnt_nxt = '0;
            blk_nxt = '0;
            fill_nxt = 8'd0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      h_r <= {IV7, IV6, IV5, IV4, IV3, IV2, IV1, IV0 ^ PARAM_WORD};
      cnt_r <= '0;
      blk_r <= '0;
      fill_r <= 8'd0;
      oidx_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      h_r <= h_nxt;
      cnt_r <= cnt_nxt;
      blk_r <= blk_nxt;
      fill_r <= fill_nxt;
      oidx_r <= oidx_nxt;
    end
    word_r <= word_nxt;
    bc_r <= bc_nxt;
    last_r <= last_nxt;
  end

endmodule
